>>> sv/bgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

    // Sizes
    localparam int BUTTONS        = 7;
    localparam int HISTORY_FRAMES = 32;
    localparam int HOLD_W         = 8;
    localparam int WINDOW_W       = 6;
    localparam int BTN_IDX_W      = 3;

    localparam logic [HOLD_W-1:0] HOLD_SAT = 8'd255;

    // Reset values of the configuration registers
    localparam logic [HOLD_W-1:0]    HOLD_THRESHOLD_RST = 8'd30;
    localparam logic [WINDOW_W-1:0]  DOUBLE_WINDOW_RST  = 6'd15;
    localparam logic [WINDOW_W-1:0]  CHORD_WINDOW_RST   = 6'd5;
    localparam logic [BTN_IDX_W-1:0] CHORD_BUTTON_A_RST = 3'd4;
    localparam logic [BTN_IDX_W-1:0] CHORD_BUTTON_B_RST = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HOLD_THRESHOLD = 3'd0,
        REG_DOUBLE_WINDOW  = 3'd1,
        REG_CHORD_WINDOW   = 3'd2,
        REG_CHORD_BUTTON_A = 3'd3,
        REG_CHORD_BUTTON_B = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [HOLD_W-1:0]    hold_threshold;
        logic [WINDOW_W-1:0]  double_window;
        logic [WINDOW_W-1:0]  chord_window;
        logic [BTN_IDX_W-1:0] chord_button_a;
        logic [BTN_IDX_W-1:0] chord_button_b;
    } cfg_t;

    typedef struct packed {
        logic [BUTTONS-1:0] held_mask;
        logic [BUTTONS-1:0] press_mask;
        logic [BUTTONS-1:0] double_query_mask;
        logic               chord_query;
    } frame_t;

    typedef struct packed {
        logic [BUTTONS-1:0] hold_flags;
        logic [BUTTONS-1:0] double_flags;
        logic               chord_flag;
    } flags_t;

    // Mask with the lowest n history bits set
    function automatic logic [HISTORY_FRAMES-1:0] low_mask(input logic [WINDOW_W-1:0] n);
        logic [HISTORY_FRAMES-1:0] m;
        for (int j = 0; j < HISTORY_FRAMES; j++) begin
            m[j] = (WINDOW_W'(j) < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> sv/button_gesture_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector
// Hold, double-press and chord detection over a stream of button frames.
// ----------------------------------------------------------------------------
//
//   channel | signals                               | carries
//   --------+---------------------------------------+-------------------------
//   frame   | frame_valid, frame_ready, frame       | one frame of button state
//   flags   | flags_valid, flags_ready, flags       | one flag set per frame
//   cfg     | cfg_valid, cfg_ready, cfg_index/data  | register write
//
// One frame per cycle: a frame is evaluated in the cycle it transfers and its
// flags appear from the output register on the next cycle. The output
// register alone sets the rate; a frame transfers whenever that register is
// empty or being drained. The cfg channel is always ready.
// Reset clears all hold counters and histories and loads the register
// defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_detector
    import bgd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   frame_valid,
    output logic                        frame_ready,
    input  wire frame_t                 frame,
    output logic                        flags_valid,
    input  wire logic                   flags_ready,
    output flags_t                      flags,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    flags_t flags_reg;
    flags_t flags_calc;
    logic   flags_valid_reg;
    logic   flags_valid_next;
    logic   frame_xfer;

    assign cfg_ready   = 1'b1;
    assign frame_ready = !flags_valid_reg || flags_ready;
    assign frame_xfer  = frame_valid && frame_ready;
    assign flags_valid = flags_valid_reg;
    assign flags       = flags_reg;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_HOLD_THRESHOLD: cfg_next.hold_threshold = cfg_data;
                REG_DOUBLE_WINDOW:  cfg_next.double_window  = cfg_data[WINDOW_W-1:0];
                REG_CHORD_WINDOW:   cfg_next.chord_window   = cfg_data[WINDOW_W-1:0];
                REG_CHORD_BUTTON_A: cfg_next.chord_button_a = cfg_data[BTN_IDX_W-1:0];
                REG_CHORD_BUTTON_B: cfg_next.chord_button_b = cfg_data[BTN_IDX_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.hold_threshold <= HOLD_THRESHOLD_RST;
            cfg_reg.double_window  <= DOUBLE_WINDOW_RST;
            cfg_reg.chord_window   <= CHORD_WINDOW_RST;
            cfg_reg.chord_button_a <= CHORD_BUTTON_A_RST;
            cfg_reg.chord_button_b <= CHORD_BUTTON_B_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Frame evaluation and state update
    bgd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (frame_xfer),
        .frame   (frame),
        .cfg     (cfg_reg),
        .flags   (flags_calc)
    );

    // Hold the result until its transfer, load on each frame transfer
    always_comb
    begin
        if (frame_xfer) begin
            flags_valid_next = 1'b1;
        end else if (flags_ready) begin
            flags_valid_next = 1'b0;
        end else begin
            flags_valid_next = flags_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flags_valid_reg <= 1'b0;
        end else begin
            flags_valid_reg <= flags_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_xfer) begin
            flags_reg <= flags_calc;
        end
    end

endmodule

`default_nettype wire

>>> sv/bgd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_core
// Per-button hold counters and press histories, updated once per frame,
// with the hold, double-press and chord evaluation of the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_core
    import bgd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire frame_t frame,
    input  wire cfg_t   cfg,
    output flags_t      flags
);

    logic [HOLD_W-1:0]         hold_count_reg     [BUTTONS];
    logic [HOLD_W-1:0]         hold_count_next    [BUTTONS];
    logic [HISTORY_FRAMES-1:0] double_history_reg [BUTTONS];
    logic [HISTORY_FRAMES-1:0] double_history_next[BUTTONS];
    logic [HISTORY_FRAMES-1:0] chord_history_reg  [BUTTONS];
    logic [HISTORY_FRAMES-1:0] chord_history_next [BUTTONS];

    logic [HISTORY_FRAMES-1:0] double_shift[BUTTONS];
    logic [HISTORY_FRAMES-1:0] chord_shift [BUTTONS];
    logic [HISTORY_FRAMES-1:0] double_win;
    logic [HISTORY_FRAMES-1:0] chord_win;
    logic [HISTORY_FRAMES-1:0] double_sel[BUTTONS];
    logic                      double_ok;
    logic                      chord_ok;
    logic                      hit_a;
    logic                      hit_b;
    logic                      chord_found;

    // Window masks and setup checks
    always_comb
    begin
        double_win = low_mask(cfg.double_window);
        chord_win  = low_mask(cfg.chord_window);
        double_ok  = (cfg.double_window >= WINDOW_W'(2)) &&
                     (cfg.double_window <  WINDOW_W'(HISTORY_FRAMES));
        chord_ok   = frame.chord_query &&
                     (cfg.chord_button_a < BTN_IDX_W'(BUTTONS)) &&
                     (cfg.chord_button_b < BTN_IDX_W'(BUTTONS)) &&
                     (cfg.chord_button_a != cfg.chord_button_b) &&
                     (cfg.chord_window != '0) &&
                     (cfg.chord_window <= WINDOW_W'(HISTORY_FRAMES));
    end

    // Shift in this frame's press edge, advance the hold counters and find the chord button hits
    always_comb
    begin
        hit_a = 1'b0;
        hit_b = 1'b0;
        for (int i = 0; i < BUTTONS; i++) begin
            double_shift[i] = {double_history_reg[i][HISTORY_FRAMES-2:0],
                               frame.press_mask[i]};
            chord_shift[i]  = {chord_history_reg[i][HISTORY_FRAMES-2:0],
                               frame.press_mask[i]};
            if (!frame.held_mask[i]) begin
                hold_count_next[i] = '0;
            end else if (hold_count_reg[i] == HOLD_SAT) begin
                hold_count_next[i] = hold_count_reg[i];
            end else begin
                hold_count_next[i] = hold_count_reg[i] + HOLD_W'(1);
            end
            if (cfg.chord_button_a == BTN_IDX_W'(i)) begin
                hit_a = |(chord_shift[i] & chord_win);
            end
            if (cfg.chord_button_b == BTN_IDX_W'(i)) begin
                hit_b = |(chord_shift[i] & chord_win);
            end
        end
        chord_found = chord_ok && hit_a && hit_b;
    end

    // Evaluate flags and clear the histories that produced a match
    always_comb
    begin
        flags.chord_flag = chord_found;
        for (int i = 0; i < BUTTONS; i++) begin
            flags.hold_flags[i] = (cfg.hold_threshold != '0) &&
                                  (hold_count_next[i] >= cfg.hold_threshold);
            // Two or more set bits: clearing the lowest one leaves a bit set
            double_sel[i] = double_shift[i] & double_win;
            flags.double_flags[i] = double_ok && frame.double_query_mask[i] &&
                                    ((double_sel[i] & (double_sel[i] -
                                      HISTORY_FRAMES'(1))) != '0);
            double_history_next[i] = flags.double_flags[i] ? '0 : double_shift[i];
            chord_history_next[i]  = (chord_found &&
                                      ((cfg.chord_button_a == BTN_IDX_W'(i)) ||
                                       (cfg.chord_button_b == BTN_IDX_W'(i))))
                                     ? '0 : chord_shift[i];
        end
    end

    // Commit the state on each frame transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < BUTTONS; i++) begin
                hold_count_reg[i]     <= '0;
                double_history_reg[i] <= '0;
                chord_history_reg[i]  <= '0;
            end
        end else if (advance) begin
            for (int i = 0; i < BUTTONS; i++) begin
                hold_count_reg[i]     <= hold_count_next[i];
                double_history_reg[i] <= double_history_next[i];
                chord_history_reg[i]  <= chord_history_next[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/bgd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level checks for the button gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_checker
    import bgd_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   frame_valid,
    input wire logic   frame_ready,
    input wire frame_t frame,
    input wire logic   flags_valid,
    input wire logic   flags_ready,
    input wire flags_t flags
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        flags_valid && !flags_ready |=> flags_valid && $stable(flags))
        else $error("stalled flags changed");

    // An empty output stage never blocks a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        !flags_valid |-> frame_ready)
        else $error("frame blocked with empty output");

    // A frame transfer yields a result in the next cycle, no chord unless queried
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && !frame.chord_query
        |=> flags_valid && !flags.chord_flag)
        else $error("chord flag without query");

    // Double flags only on queried buttons
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready
        |=> (flags.double_flags & ~$past(frame.double_query_mask)) == '0)
        else $error("double flag on unqueried button");

    // Hold flags only on held buttons
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready
        |=> (flags.hold_flags & ~$past(frame.held_mask)) == '0)
        else $error("hold flag on released button");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .flags_valid (flags_valid),
    .flags_ready (flags_ready),
    .flags       (flags)
);

`default_nettype wire

>>> tb/button_gesture_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_tb
// Self-checking bench for hold, double-press and chord detection.
//
// Frames go in over the frame channel, and an in-bench predictor of the
// counters and press histories works out the flags for each one. The flags
// channel output is compared field by field against the queue of predicted
// flags. Settings are written between phases, once the block has drained.
// Both sides idle at random. One phase holds off the flags channel for a long
// stretch so that the frame channel backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_detector_tb;

    import bgd_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;

    // DUT signals
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   frame_valid;
    logic                   frame_ready;
    frame_t                 frame;
    logic                   flags_valid;
    logic                   flags_ready = 1'b0;
    flags_t                 flags;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state
    logic [HOLD_W-1:0]         hold_cnt [BUTTONS];
    logic [HISTORY_FRAMES-1:0] dbl_hist [BUTTONS];
    logic [HISTORY_FRAMES-1:0] chd_hist [BUTTONS];
    cfg_t                      cfg_model;
    flags_t                    expected_flags [$];

    // Stimulus and bookkeeping
    logic [BUTTONS-1:0] pad_down;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 holdoff_requests = 0;
    int                 holdoff_served   = 0;
    int                 stall_left       = 0;
    int                 mismatches       = 0;
    int                 cycle_count      = 0;

    button_gesture_detector i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .flags_valid (flags_valid),
        .flags_ready (flags_ready),
        .flags       (flags),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Drive flags_ready: honor a hold-off request first, else idle at random
    always @(negedge clk)
    begin
        if (holdoff_requests != holdoff_served)
        begin
            holdoff_served = holdoff_requests;
            stall_left     = HOLDOFF_CYCLES;
        end
        if (stall_left != 0)
        begin
            flags_ready = 1'b0;
            stall_left--;
        end
        else
        begin
            flags_ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Compare each flags transfer with the oldest prediction
    always @(posedge clk)
    begin : check_flags
        flags_t want;
        if (rst_n && flags_valid && flags_ready)
        begin
            if (expected_flags.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("flags transfer with nothing predicted: hold=%h dbl=%h chord=%b",
                             flags.hold_flags, flags.double_flags, flags.chord_flag);
            end
            else
            begin
                want = expected_flags.pop_front();
                if (flags.hold_flags !== want.hold_flags ||
                    flags.double_flags !== want.double_flags ||
                    flags.chord_flag !== want.chord_flag)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"flags mismatch: want hold=%h dbl=%h chord=%b,",
                                  " got hold=%h dbl=%h chord=%b"},
                                 want.hold_flags, want.double_flags, want.chord_flag,
                                 flags.hold_flags, flags.double_flags, flags.chord_flag);
                end
            end
        end
    end

    // Mask of the lowest n history frames
    function automatic logic [HISTORY_FRAMES-1:0] window_mask(input int unsigned n);
        if (n >= HISTORY_FRAMES)
            return '1;
        return HISTORY_FRAMES'((64'd1 << n) - 64'd1);
    endfunction

    // Advance the predictor by one frame and return the flags it raises
    function automatic flags_t predict_flags(input frame_t f);
        flags_t                    r;
        logic [HISTORY_FRAMES-1:0] wm;
        int unsigned               a;
        int unsigned               b;
        r = '0;
        for (int i = 0; i < BUTTONS; i++)
        begin
            dbl_hist[i] = {dbl_hist[i][HISTORY_FRAMES-2:0], f.press_mask[i]};
            if (f.held_mask[i])
            begin
                if (hold_cnt[i] != HOLD_SAT)
                    hold_cnt[i] = hold_cnt[i] + 1'b1;
            end
            else
            begin
                hold_cnt[i] = '0;
            end
            chd_hist[i] = {chd_hist[i][HISTORY_FRAMES-2:0], f.press_mask[i]};
        end

        for (int i = 0; i < BUTTONS; i++)
            r.hold_flags[i] = (cfg_model.hold_threshold != 0) &&
                              (hold_cnt[i] >= cfg_model.hold_threshold);

        // Double press: a second press in the window of a queried button clears that history
        if (cfg_model.double_window >= 2 && cfg_model.double_window < HISTORY_FRAMES)
        begin
            wm = window_mask(cfg_model.double_window);
            for (int i = 0; i < BUTTONS; i++)
            begin
                if (f.double_query_mask[i] && $countones(dbl_hist[i] & wm) >= 2)
                begin
                    dbl_hist[i]       = '0;
                    r.double_flags[i] = 1'b1;
                end
            end
        end

        // Chord: both buttons seen in the window clear both histories
        a = cfg_model.chord_button_a;
        b = cfg_model.chord_button_b;
        if (f.chord_query && a < BUTTONS && b < BUTTONS && a != b &&
            cfg_model.chord_window != 0 && cfg_model.chord_window <= HISTORY_FRAMES)
        begin
            wm = window_mask(cfg_model.chord_window);
            if ((chd_hist[a] & wm) != 0 && (chd_hist[b] & wm) != 0)
            begin
                chd_hist[a]  = '0;
                chd_hist[b]  = '0;
                r.chord_flag = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic frame_t frame_of(input logic [BUTTONS-1:0] held,
                                        input logic [BUTTONS-1:0] press,
                                        input logic [BUTTONS-1:0] dq,
                                        input logic               cq);
        frame_t f;
        f.held_mask         = held;
        f.press_mask        = press;
        f.double_query_mask = dq;
        f.chord_query       = cq;
        return f;
    endfunction

    // Offer one frame and record its prediction on transfer; returns at a falling edge
    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < src_idle_pct)
        begin
            frame_valid = 1'b0;
            @(negedge clk);
        end
        frame       = f;
        frame_valid = 1'b1;
        do
            @(posedge clk);
        while (!frame_ready);
        expected_flags.push_back(predict_flags(f));
        @(negedge clk);
    endtask

    // Drop frame_valid and wait until every prediction has been matched
    task automatic wait_drained();
        frame_valid = 1'b0;
        while (expected_flags.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Write all five registers while the block is idle
    task automatic apply_config(input cfg_t c);
        cfg_reg_t sel;
        wait_drained();
        sel = sel.first();
        do
        begin
            cfg_valid = 1'b1;
            cfg_index = sel;
            case (sel)
                REG_HOLD_THRESHOLD: cfg_data = c.hold_threshold;
                REG_DOUBLE_WINDOW:  cfg_data = CFG_DATA_W'(c.double_window);
                REG_CHORD_WINDOW:   cfg_data = CFG_DATA_W'(c.chord_window);
                REG_CHORD_BUTTON_A: cfg_data = CFG_DATA_W'(c.chord_button_a);
                default:            cfg_data = CFG_DATA_W'(c.chord_button_b);
            endcase
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
            sel = sel.next();
        end
        while (sel != sel.first());
        cfg_valid = 1'b0;
        cfg_model = c;
    endtask

    // Mostly usable settings, with the out-of-range ones now and then
    function automatic cfg_t rand_config();
        cfg_t c;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 60)
            c.hold_threshold = HOLD_W'($urandom_range(1, 6));
        else if (pick < 70)
            c.hold_threshold = '0;
        else if (pick < 80)
            c.hold_threshold = HOLD_SAT;
        else
            c.hold_threshold = HOLD_W'($urandom_range(0, 255));

        if ($urandom_range(99) < 80)
            c.double_window = WINDOW_W'($urandom_range(2, HISTORY_FRAMES - 1));
        else
            c.double_window = ($urandom_range(2) == 0) ? 6'd0 :
                              ($urandom_range(1) == 0) ? 6'd1 : 6'(HISTORY_FRAMES);

        c.chord_window = ($urandom_range(99) < 85)
                         ? WINDOW_W'($urandom_range(1, HISTORY_FRAMES)) : 6'd0;

        if ($urandom_range(99) < 85)
        begin
            c.chord_button_a = BTN_IDX_W'($urandom_range(0, BUTTONS - 1));
            c.chord_button_b = BTN_IDX_W'((c.chord_button_a +
                                           $urandom_range(1, BUTTONS - 1)) % BUTTONS);
        end
        else
        begin
            c.chord_button_a = BTN_IDX_W'($urandom_range(0, 7));
            c.chord_button_b = BTN_IDX_W'($urandom_range(0, 7));
        end
        return c;
    endfunction

    // Next frame of a plausible pad session, with some raw noise mixed in
    task automatic next_gesture(output frame_t f);
        logic [BUTTONS-1:0] now_down;
        logic [BUTTONS-1:0] dq;
        if ($urandom_range(99) < 10)
        begin
            f = frame_of(BUTTONS'($urandom_range(0, 127)), BUTTONS'($urandom_range(0, 127)),
                         BUTTONS'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            for (int i = 0; i < BUTTONS; i++)
            begin
                if (pad_down[i])
                    now_down[i] = ($urandom_range(99) >= 35);
                else
                    now_down[i] = ($urandom_range(99) < 30);
                dq[i] = ($urandom_range(99) < 35);
            end
            f        = frame_of(now_down, now_down & ~pad_down, dq, ($urandom_range(99) < 40));
            pad_down = now_down;
        end
    endtask

    // Reset defaults: field extremes, double press, chord and its misses
    task automatic test_directed();
        send_frame(frame_of('0, '0, '0, 1'b0));
        send_frame(frame_of('1, '1, '1, 1'b1));
        send_frame(frame_of('1, '1, '0, 1'b1));
        send_frame(frame_of('1, '0, '1, 1'b0));
        send_frame(frame_of('0, 7'h10, '0, 1'b1));
        send_frame(frame_of('0, 7'h20, '0, 1'b1));
        send_frame(frame_of(7'h01, 7'h01, 7'h01, 1'b0));
        // second press of button 0 fourteen frames later still lands in the window
        repeat (13) send_frame(frame_of('0, '0, '0, 1'b0));
        send_frame(frame_of(7'h01, 7'h01, 7'h01, 1'b0));
        send_frame(frame_of(7'h40, 7'h40, 7'h40, 1'b1));
    endtask

    task automatic sweep_setting(input cfg_t c);
        frame_t f;
        apply_config(c);
        send_frame(frame_of('1, '1, '0, 1'b1));
        send_frame(frame_of('1, '1, '1, 1'b1));
        send_frame(frame_of('0, '0, '1, 1'b1));
        repeat (15)
        begin
            next_gesture(f);
            send_frame(f);
        end
    endtask

    // Window and index extremes, hold disabled and hold at maximum
    task automatic test_window_extremes();
        sweep_setting('{8'd0,   6'd2,  6'd1,  3'd0, 3'd6});
        sweep_setting('{8'd1,   6'd31, 6'd32, 3'd6, 3'd0});
        sweep_setting('{8'd255, 6'd32, 6'd0,  3'd3, 3'd3});
        sweep_setting('{8'd2,   6'd1,  6'd16, 3'd7, 3'd2});
        sweep_setting('{8'd3,   6'd0,  6'd32, 3'd2, 3'd7});
        sweep_setting('{8'd255, 6'd16, 6'd8,  3'd1, 3'd2});
        sweep_setting('{8'd1,   6'd3,  6'd2,  3'd5, 3'd4});
    endtask

    task automatic test_random_gestures(input int n);
        frame_t f;
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
                apply_config(rand_config());
            next_gesture(f);
            send_frame(f);
        end
    endtask

    // Hold every button past saturation, then lower the threshold mid-hold
    task automatic test_hold_saturation();
        cfg_t c;
        c = cfg_model;
        c.hold_threshold = HOLD_SAT;
        apply_config(c);
        send_frame(frame_of('0, '0, '0, 1'b0));
        send_frame(frame_of('1, '1, '0, 1'b0));
        repeat (259)
            send_frame(frame_of('1, '0, BUTTONS'($urandom_range(0, 127)),
                                1'($urandom_range(0, 1))));
        c.hold_threshold = 8'd200;
        apply_config(c);
        repeat (3) send_frame(frame_of('1, '0, '0, 1'b0));
        send_frame(frame_of('0, '0, '0, 1'b0));
        pad_down = '0;
    endtask

    // Stall the flags channel while frames keep coming
    task automatic test_backpressure();
        frame_t f;
        holdoff_requests++;
        repeat (40)
        begin
            next_gesture(f);
            send_frame(f);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        frame_valid   = 1'b0;
        frame         = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pad_down      = '0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int i = 0; i < BUTTONS; i++)
        begin
            hold_cnt[i] = '0;
            dbl_hist[i] = '0;
            chd_hist[i] = '0;
        end
        cfg_model = '{HOLD_THRESHOLD_RST, DOUBLE_WINDOW_RST, CHORD_WINDOW_RST,
                      CHORD_BUTTON_A_RST, CHORD_BUTTON_B_RST};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct  = 15;
        sink_idle_pct = 81;
        test_directed();
        test_window_extremes();

        src_idle_pct  = 81;
        sink_idle_pct = 15;
        test_random_gestures(300);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_hold_saturation();
        test_backpressure();
        test_random_gestures(100);

        // Drain, then keep watching for stray transfers before the verdict
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && expected_flags.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
